// ===== src/regex_dot_star_match_unit_macros.svh =====
// Assertion macros shared by the pattern match unit.
`ifndef REGEX_DOT_STAR_MATCH_UNIT_MACROS_SVH
`define REGEX_DOT_STAR_MATCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cond implies conseq in the same cycle.
`define RDSM_ASSERT_NOW(lbl, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("rdsm: same-cycle check failed");

// Check that cond implies conseq in the following cycle.
`define RDSM_ASSERT_NEXT(lbl, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("rdsm: next-cycle check failed");

`else

`define RDSM_ASSERT_NOW(lbl, cond, conseq)
`define RDSM_ASSERT_NEXT(lbl, cond, conseq)

`endif

`endif

// ===== src/rdsm_pkg.sv =====
// Shared constants and types of the pattern match unit.
`default_nettype none

package rdsm_pkg;

    // Pattern columns and widths
    localparam int PATTERN_MAX = 16;
    localparam int COLS        = PATTERN_MAX + 1;
    localparam int COL_W       = $clog2(COLS);
    localparam int BYTE_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_LEN_W   = 5;
    localparam int CFG_IDX_W   = 2;

    // Pattern byte codes
    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [BYTE_W-1:0] DOT_BYTE  = 8'h2E;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

    // Bits one column hands to the columns to its right
    typedef struct packed {
        logic emp;   // column of the empty-text row
        logic base;  // column of the row the new byte starts from
        logic nxt;   // column of the new row
        logic held;  // stored column bit
    } link_t;

    localparam link_t LINK_ZERO = '{emp: 1'b0, base: 1'b0, nxt: 1'b0, held: 1'b0};

endpackage

`default_nettype wire

// ===== src/rdsm_text_if.sv =====
// Request channel carrying one text byte and its framing flags.
`default_nettype none

interface rdsm_text_if
    import rdsm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              first_byte;
    logic              last_byte;
    logic              empty_text;

    modport source (output valid, text_byte, first_byte, last_byte, empty_text, input ready);
    modport sink (input valid, text_byte, first_byte, last_byte, empty_text, output ready);
endinterface

`default_nettype wire

// ===== src/rdsm_result_if.sv =====
// Result channel carrying the match flag of one string.
`default_nettype none

interface rdsm_result_if
    import rdsm_pkg::*;
();
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, matched, input ready);
    modport sink (input valid, matched, output ready);
endinterface

`default_nettype wire

// ===== src/rdsm_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface rdsm_cfg_if
    import rdsm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/regex_dot_star_match_unit.sv =====
// A finishing request's result sits in the output register in the cycle after acceptance.
// Throughput: one text byte per cycle when not stalled; the new row ripples through
// the column cells in that cycle, the longest path running along a run of star columns.
// A new request is taken while a result waits, as long as the result is taken that cycle.
// Reset: pattern and length clear, match row holds only column zero, output register empty.
`default_nettype none
`include "regex_dot_star_match_unit_macros.svh"

module regex_dot_star_match_unit
    import rdsm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    rdsm_text_if.sink     text_req,
    rdsm_result_if.source match_rsp,
    rdsm_cfg_if.sink      cfg_wr
);

    logic [CFG_DATA_W-1:0]   pat_low_reg;
    logic [CFG_DATA_W-1:0]   pat_high_reg;
    logic [CFG_LEN_W-1:0]    pat_len_reg;
    logic [2*CFG_DATA_W-1:0] pat_all;
    logic [COL_W-1:0]        m_eff;
    logic                    row0_reg;
    logic                    out_vld_reg;
    logic                    out_vld_next;
    logic                    out_match_reg;
    logic                    out_match_next;
    logic                    accept;
    logic                    has_result;
    logic [COLS-1:0]         res_row;
    logic [COLS-1:0]         row_vec;
    link_t                   col_link [COLS];

    // Write configuration registers
    assign cfg_wr.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                REG_PAT_LOW:  pat_low_reg  <= cfg_wr.data;
                REG_PAT_HIGH: pat_high_reg <= cfg_wr.data;
                REG_PAT_LEN:  pat_len_reg  <= cfg_wr.data[CFG_LEN_W-1:0];
                default:      pat_len_reg  <= pat_len_reg;
            endcase
        end
    end

    assign pat_all = {pat_high_reg, pat_low_reg};
    assign m_eff   = (pat_len_reg > CFG_LEN_W'(PATTERN_MAX)) ? COL_W'(PATTERN_MAX)
                                                             : COL_W'(pat_len_reg);

    // Accept a request whenever the output register is free or drains this cycle
    assign text_req.ready = !out_vld_reg || match_rsp.ready;
    assign accept         = text_req.valid && text_req.ready;
    assign has_result     = text_req.last_byte || text_req.empty_text;

    // Column zero: set only in the empty-text row
    assign col_link[0].emp  = 1'b1;
    assign col_link[0].base = text_req.first_byte ? 1'b1 : row0_reg;
    assign col_link[0].nxt  = 1'b0;
    assign col_link[0].held = row0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg <= 1'b1;
        end
        else if (accept)
        begin
            row0_reg <= text_req.empty_text;
        end
    end

    // Row of column cells, each fed by its two left neighbors
    for (genvar j = 1; j < COLS; j++)
    begin : g_col
        localparam int PrevIdx = (j >= 2) ? j - 2 : 0;
        logic        used;
        logic [BYTE_W-1:0] pat_prev;
        link_t       left2;

        assign used     = (COL_W'(j) <= m_eff);
        assign pat_prev = (j >= 2) ? pat_all[BYTE_W*PrevIdx +: BYTE_W] : '0;
        assign left2    = (j >= 2) ? col_link[PrevIdx] : LINK_ZERO;

        rdsm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (accept),
            .empty     (text_req.empty_text),
            .first     (text_req.first_byte),
            .text_byte (text_req.text_byte),
            .pat_cur   (pat_all[BYTE_W*(j-1) +: BYTE_W]),
            .pat_prev  (pat_prev),
            .used      (used),
            .lead      (j == 1),
            .left1     (col_link[j-1]),
            .left2     (left2),
            .link      (col_link[j])
        );
    end

    // Gather the row that decides the result
    always_comb
    begin
        for (int k = 0; k < COLS; k++)
        begin
            res_row[k] = text_req.empty_text ? col_link[k].emp : col_link[k].nxt;
            row_vec[k] = col_link[k].held;
        end
    end

    // Load the output register on a finishing request, drop it once taken
    always_comb
    begin
        out_vld_next   = out_vld_reg;
        out_match_next = out_match_reg;
        if (accept && has_result)
        begin
            out_vld_next   = 1'b1;
            out_match_next = res_row[m_eff];
        end
        else if (match_rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_match_reg <= out_match_next;
    end

    assign match_rsp.valid   = out_vld_reg;
    assign match_rsp.matched = out_match_reg;

    // Checks on row and output bookkeeping
    `RDSM_ASSERT_NEXT(a_empty_sets_col0, accept && text_req.empty_text, row0_reg)
    `RDSM_ASSERT_NEXT(a_byte_clears_col0, accept && !text_req.empty_text, !row0_reg)
    `RDSM_ASSERT_NEXT(a_result_loaded, accept && has_result, out_vld_reg)
    `RDSM_ASSERT_NEXT(a_unused_cols_clear, accept,
        ((row_vec >> $past(m_eff)) >> 1) == '0)
    `RDSM_ASSERT_NOW(a_ready_when_free, !out_vld_reg, text_req.ready)

endmodule

`default_nettype wire

// ===== src/rdsm_cell.sv =====
// One pattern column of the match row: holds its bit and computes the next one.
`default_nettype none

module rdsm_cell
    import rdsm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic              empty,
    input  wire logic              first,
    input  wire logic [BYTE_W-1:0] text_byte,
    input  wire logic [BYTE_W-1:0] pat_cur,
    input  wire logic [BYTE_W-1:0] pat_prev,
    input  wire logic              used,
    input  wire logic              lead,
    input  wire link_t             left1,
    input  wire link_t             left2,
    output link_t                  link
);

    logic row_reg;
    logic row_next;
    logic is_star;
    logic emp_bit;
    logic base_bit;
    logic nxt_bit;
    logic prev_hits;

    assign is_star   = (pat_cur == STAR_BYTE);
    assign prev_hits = (pat_prev == text_byte) || (pat_prev == DOT_BYTE);

    // Empty-text row: a star closes the two columns before it
    assign emp_bit  = used && !lead && is_star && left2.emp;
    assign base_bit = first ? emp_bit : row_reg;

    // New row bit from the starting row and the columns to the left
    always_comb
    begin
        nxt_bit = 1'b0;
        if (!used || lead && is_star)
        begin
            nxt_bit = 1'b0;
        end
        else if (pat_cur == DOT_BYTE)
        begin
            nxt_bit = left1.base;
        end
        else if (!is_star)
        begin
            nxt_bit = left1.base && (text_byte == pat_cur);
        end
        else if (!prev_hits)
        begin
            nxt_bit = left2.nxt;
        end
        else
        begin
            nxt_bit = base_bit || left1.nxt || left2.nxt;
        end
    end

    assign row_next = load ? (empty ? emp_bit : nxt_bit) : row_reg;

    // Hold the column bit between requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign link.emp  = emp_bit;
    assign link.base = base_bit;
    assign link.nxt  = nxt_bit;
    assign link.held = row_reg;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the streamed regex pattern match unit.
`timescale 1ns / 100ps

module tb
    import rdsm_pkg::*;
();

    localparam int ITEM_TARGET = 1600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              first_byte;
        logic              last_byte;
        logic              empty_text;
    } text_item_t;

    logic clk = 1'b0;
    logic rst_n;

    rdsm_text_if   text_ch ();
    rdsm_result_if match_ch ();
    rdsm_cfg_if    cfg_ch ();

    regex_dot_star_match_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_req  (text_ch),
        .match_rsp (match_ch),
        .cfg_wr    (cfg_ch)
    );

    // Predictor copy of the pattern registers and the stored table row
    logic [CFG_DATA_W-1:0] pat_low;
    logic [CFG_DATA_W-1:0] pat_high;
    logic [CFG_LEN_W-1:0]  pat_len;
    logic [COLS-1:0]       match_row;

    logic expected_matches[$];
    int   mismatches = 0;
    int   items_sent = 0;
    int   cycle_count = 0;
    int   burst_left = 0;
    bit   gaps_on = 1'b1;
    int   hold_off_cycles = 0;

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("regex_dot_star_match_unit: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [BYTE_W-1:0] pattern_at(int k);
        if (k < 8)
            return pat_low[8*k +: 8];
        else if (k < 16)
            return pat_high[8*(k-8) +: 8];
        return '0;
    endfunction

    function automatic int used_len();
        return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    endfunction

    // Row for the empty text: each star column may close the two bytes before it
    function automatic logic [COLS-1:0] empty_text_row(int m);
        logic [COLS-1:0] row;
        row = '0;
        row[0] = 1'b1;
        for (int j = 2; j <= m; j++)
            if (pattern_at(j - 1) == STAR_BYTE && row[j-2])
                row[j] = 1'b1;
        return row;
    endfunction

    // Advance the table row by one text byte
    function automatic logic [COLS-1:0] row_after_byte(logic [COLS-1:0] prev,
                                                       logic [BYTE_W-1:0] c, int m);
        logic [COLS-1:0]   row;
        logic [BYTE_W-1:0] pc;
        logic [BYTE_W-1:0] pb;
        logic              v;
        row = '0;
        for (int j = 1; j <= m; j++)
        begin
            pc = pattern_at(j - 1);
            if (pc == DOT_BYTE)
                v = prev[j-1];
            else if (pc != STAR_BYTE)
                v = prev[j-1] && (c == pc);
            else if (j < 2)
                v = 1'b0;  // star with nothing to repeat
            else
            begin
                pb = pattern_at(j - 2);
                if (pb != c && pb != DOT_BYTE)
                    v = row[j-2];
                else
                    v = prev[j] | row[j-1] | row[j-2];
            end
            row[j] = v;
        end
        return row;
    endfunction

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin : check_results
        logic want;
        if (rst_n && match_ch.valid && match_ch.ready)
        begin
            if (expected_matches.size() == 0)
                report_mismatch($sformatf("result with none pending, matched=%0b",
                                          match_ch.matched));
            else
            begin
                want = expected_matches.pop_front();
                if (match_ch.matched !== want)
                    report_mismatch($sformatf("matched=%0b, predicted %0b",
                                              match_ch.matched, want));
            end
        end
    end

    // Result ready: changing stall modes, plus a long hold-off on request
    initial
    begin : drive_result_ready
        int stall_mode;
        int mode_left;
        stall_mode = 0;
        mode_left = 0;
        match_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                match_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
                match_ch.ready <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (stall_mode)
                    0: match_ch.ready <= 1'b1;
                    1: match_ch.ready <= ($urandom_range(0, 9) >= 3);
                    2: match_ch.ready <= ((mode_left % 5) >= 2);
                    default: match_ch.ready <= ($urandom_range(0, 9) >= 7);
                endcase
            end
        end
    end

    // Send one request in bursts with random gaps, then predict its result
    task automatic send_item(text_item_t it);
        int gap;
        int m;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        text_ch.valid      <= 1'b1;
        text_ch.text_byte  <= it.text_byte;
        text_ch.first_byte <= it.first_byte;
        text_ch.last_byte  <= it.last_byte;
        text_ch.empty_text <= it.empty_text;
        @(posedge clk);
        while (!text_ch.ready) @(posedge clk);
        items_sent++;
        m = used_len();
        if (it.empty_text)
        begin
            match_row = empty_text_row(m);
            expected_matches.push_back(match_row[m]);
        end
        else
        begin
            match_row = row_after_byte(it.first_byte ? empty_text_row(m) : match_row,
                                       it.text_byte, m);
            if (it.last_byte)
                expected_matches.push_back(match_row[m]);
        end
    endtask

    // Drain all results and let the last no-result request settle
    task automatic wait_idle();
        text_ch.valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            REG_PAT_LOW:  pat_low = data;
            REG_PAT_HIGH: pat_high = data;
            REG_PAT_LEN:  pat_len = data[CFG_LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
                              logic [CFG_LEN_W-1:0] len);
        wait_idle();
        write_reg(REG_PAT_LOW, lo);
        write_reg(REG_PAT_HIGH, hi);
        write_reg(REG_PAT_LEN, {{(CFG_DATA_W-CFG_LEN_W){1'b0}}, len});
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_pattern(string p, logic [CFG_LEN_W-1:0] len);
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        lo = '0;
        hi = '0;
        for (int k = 0; k < p.len() && k < 16; k++)
            if (k < 8)
                lo[8*k +: 8] = p[k];
            else
                hi[8*(k-8) +: 8] = p[k];
        set_config(lo, hi, len);
    endtask

    // Send a whole string; an empty one goes as a single empty-text request
    task automatic send_string(string s);
        text_item_t it;
        if (s.len() == 0)
        begin
            it = '{text_byte: 8'h00, first_byte: 1'b0, last_byte: 1'b0, empty_text: 1'b1};
            send_item(it);
        end
        for (int i = 0; i < s.len(); i++)
        begin
            it = '{text_byte: s[i], first_byte: (i == 0), last_byte: (i == s.len() - 1),
                   empty_text: 1'b0};
            send_item(it);
        end
    endtask

    function automatic logic [BYTE_W-1:0] random_text_char(int m);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return BYTE_W'($urandom);
        if (r < 7 && m > 0)
            return pattern_at($urandom_range(0, m - 1));
        return 8'h61 + BYTE_W'($urandom_range(0, 2));
    endfunction

    // Random pattern over a small alphabet, or raw register values
    task automatic random_pattern_config();
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_LEN_W-1:0]  len;
        logic [BYTE_W-1:0]     b;
        int                    s;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if ($urandom_range(0, 4) != 0)
        begin
            for (int k = 0; k < 16; k++)
            begin
                s = $urandom_range(0, 9);
                if (s <= 2)
                    b = 8'h61 + BYTE_W'(s);
                else if (s <= 5)
                    b = STAR_BYTE;
                else if (s <= 7)
                    b = DOT_BYTE;
                else
                    b = 8'h61;
                if (k < 8)
                    lo[8*k +: 8] = b;
                else
                    hi[8*(k-8) +: 8] = b;
            end
        end
        case ($urandom_range(0, 9))
            0: len = 5'd0;
            1: len = 5'd16;
            2: len = 5'd31;
            3: len = CFG_LEN_W'($urandom_range(17, 30));
            default: len = CFG_LEN_W'($urandom_range(1, 10));
        endcase
        set_config(lo, hi, len);
    endtask

    // Random string: a lone request, pattern-built or random bytes, some broken framing
    task automatic send_random_string();
        int                kind;
        int                m;
        int                k;
        int                n;
        bit                broken;
        logic [BYTE_W-1:0] pc;
        logic [BYTE_W-1:0] chars[$];
        text_item_t        it;
        kind = $urandom_range(0, 99);
        m = used_len();
        it.text_byte = BYTE_W'($urandom);
        it.first_byte = 1'($urandom_range(0, 1));
        it.last_byte = 1'($urandom_range(0, 1));
        if (kind < 14)
        begin
            it.empty_text = (kind >= 8) || ($urandom_range(0, 3) == 0);
            send_item(it);
            return;
        end
        if (kind < 55)
        begin
            k = 0;
            while (k < m && chars.size() < 24)
            begin
                pc = pattern_at(k);
                if (pc == STAR_BYTE)
                    k++;
                else if (k + 1 < m && pattern_at(k + 1) == STAR_BYTE)
                begin
                    repeat ($urandom_range(0, 3))
                        chars.push_back(pc == DOT_BYTE ? random_text_char(m) : pc);
                    k += 2;
                end
                else
                begin
                    chars.push_back(pc == DOT_BYTE ? random_text_char(m) : pc);
                    k++;
                end
            end
            if ($urandom_range(0, 4) == 0 && chars.size() > 0)
                chars[$urandom_range(0, chars.size() - 1)] = random_text_char(m);
        end
        else
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
            repeat (n) chars.push_back(random_text_char(m));
        end
        if (chars.size() == 0)
        begin
            it.empty_text = 1'b1;
            send_item(it);
            return;
        end
        broken = (kind >= 90);
        for (int i = 0; i < chars.size(); i++)
        begin
            it.text_byte = chars[i];
            it.first_byte = (i == 0) && !(broken && $urandom_range(0, 1));
            it.last_byte = (i == chars.size() - 1) && !(broken && $urandom_range(0, 1));
            it.empty_text = 1'b0;
            send_item(it);
        end
    endtask

    // Reset pattern: length zero, empty text matches, any byte does not
    task automatic test_reset_state();
        send_string("");
        send_string("z");
    endtask

    task automatic test_dot_star();
        set_pattern(".*", 5'd2);
        send_string("ab");
        send_string("");
    endtask

    // Star in the first column never matches
    task automatic test_leading_star();
        set_pattern("*a", 5'd2);
        send_string("");
        send_string("a");
    endtask

    // Second star repeats a literal star byte
    task automatic test_star_after_star();
        set_pattern("a**", 5'd3);
        send_string("a**");
    endtask

    // Length above the pattern maximum clamps to the full pattern
    task automatic test_length_clamp();
        set_pattern(".*.*.*.*.*.*.*.*", 5'd31);
        send_string("xyz");
    endtask

    // Pattern bytes and text bytes at 0x00 and 0xFF
    task automatic test_byte_extremes();
        set_config(64'h0000_0000_0000_FF00, {CFG_DATA_W{1'b1}}, 5'd2);
        send_item('{text_byte: 8'h00, first_byte: 1'b1, last_byte: 1'b0, empty_text: 1'b0});
        send_item('{text_byte: 8'hFF, first_byte: 1'b0, last_byte: 1'b1, empty_text: 1'b0});
    endtask

    // Bytes without a first flag extend the stored row, even past a finished string
    task automatic test_no_first_byte();
        set_pattern("ab", 5'd2);
        send_string("ab");
        send_item('{text_byte: 8'h62, first_byte: 1'b0, last_byte: 1'b1, empty_text: 1'b0});
    endtask

    // Stored row carries over to a new pattern
    task automatic test_pattern_change_midstring();
        set_pattern("ab", 5'd2);
        send_item('{text_byte: 8'h61, first_byte: 1'b1, last_byte: 1'b0, empty_text: 1'b0});
        set_pattern("a.c", 5'd3);
        send_item('{text_byte: 8'h78, first_byte: 1'b0, last_byte: 1'b0, empty_text: 1'b0});
        send_item('{text_byte: 8'h63, first_byte: 1'b0, last_byte: 1'b1, empty_text: 1'b0});
    endtask

    // Framing flags are ignored on an empty-text request
    task automatic test_flags_on_empty();
        send_item('{text_byte: 8'hFF, first_byte: 1'b1, last_byte: 1'b1, empty_text: 1'b1});
    endtask

    // Hold the result side off while requests keep coming, so the input stalls
    task automatic test_receiver_holdoff();
        random_pattern_config();
        gaps_on = 1'b0;
        hold_off_cycles = 400;
        repeat (16) send_random_string();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_strings();
        while (items_sent < ITEM_TARGET)
        begin
            random_pattern_config();
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(20, 50)) send_random_string();
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        text_ch.valid      <= 1'b0;
        text_ch.text_byte  <= '0;
        text_ch.first_byte <= 1'b0;
        text_ch.last_byte  <= 1'b0;
        text_ch.empty_text <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_PAT_LOW;
        cfg_ch.data        <= '0;
        pat_low = '0;
        pat_high = '0;
        pat_len = '0;
        match_row = COLS'(1);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_dot_star();
        test_leading_star();
        test_star_after_star();
        test_length_clamp();
        test_byte_extremes();
        test_no_first_byte();
        test_pattern_change_midstring();
        test_flags_on_empty();
        test_receiver_holdoff();
        test_random_strings();

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("regex_dot_star_match_unit: match");
        else
            $display("regex_dot_star_match_unit: mismatch");
        $finish;
    end

endmodule

// ===== regex_dot_star_match_unit.f =====
+incdir+src
src/rdsm_pkg.sv
src/rdsm_text_if.sv
src/rdsm_result_if.sv
src/rdsm_cfg_if.sv
src/rdsm_cell.sv
src/regex_dot_star_match_unit.sv
sim/tb.sv
